[design/i2ctmb_pkg.sv]
// ----------------------------------------------------------------------------
// i2ctmb_pkg
// Shared types and codes for the I2C target memory back end: bus event codes,
// transfer phase codes and the request and response payload structs.
// ----------------------------------------------------------------------------
package i2ctmb_pkg;

	// Bus event carried by one request.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_ACK   = 2'd1,
		OP_NACK  = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	// Transfer phase codes. Codes above PH_DATA are unused and inert.
	localparam logic [2:0] PH_H_WR = 3'd0;
	localparam logic [2:0] PH_L_WR = 3'd1;
	localparam logic [2:0] PH_H_RD = 3'd2;
	localparam logic [2:0] PH_L_RD = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	// Width of the pointer value formed from two received bytes.
	localparam int unsigned RAW_PTR_W = 16;

	typedef struct packed {
		op_t        operation;
		logic [7:0] rx_byte;
		logic       read_direction;
	} req_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
	} rsp_t;

endpackage

[design/i2ctmb_mem.sv]
// ----------------------------------------------------------------------------
// i2ctmb_mem
// Byte memory with one write port and one read port. Read data is registered,
// so it appears in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module i2ctmb_mem #(
	parameter int unsigned MEM_DEPTH = 256,
	parameter int unsigned PW        = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [PW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [PW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [MEM_DEPTH];
	logic [7:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/i2ctmb_ptr_reduce.sv]
// ----------------------------------------------------------------------------
// i2ctmb_ptr_reduce
// Reduces a 16-bit pointer value modulo the memory depth in three pipelined
// steps: reciprocal multiply, quotient times depth, subtract and correct.
// ----------------------------------------------------------------------------
module i2ctmb_ptr_reduce
	import i2ctmb_pkg::*;
#(
	parameter int unsigned MEM_DEPTH = 256,
	parameter int unsigned PW        = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAW_PTR_W-1:0] value,
	output logic                 done,
	output logic [PW-1:0]        result
);

	// Rounded-up reciprocal of the depth, scaled by two to the 32nd.
	localparam logic [32:0] RECIP =
		33'(((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH));
	localparam logic [16:0] DEPTH_W = 17'(MEM_DEPTH);

	logic                 v_s1, v_s2, done_q;
	logic [RAW_PTR_W-1:0] x_s1, x_s2;
	logic [48:0]          prod_s1;
	logic [16:0]          qd_s2;
	logic [32:0]          qd_full;
	logic [16:0]          diff;
	logic [16:0]          corr;
	logic [PW-1:0]        result_q;

	assign qd_full = {17'd0, prod_s1[47:32]} * {16'd0, DEPTH_W};
	assign diff    = {1'b0, x_s2} - qd_s2;
	assign corr    = (diff >= DEPTH_W) ? (diff - DEPTH_W) : diff;

	// Step valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		x_s1     <= value;
		prod_s1  <= {33'd0, value} * {16'd0, RECIP};
		x_s2     <= x_s1;
		qd_s2    <= qd_full[16:0];
		result_q <= corr[PW-1:0];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[design/i2c_target_memory_backend.sv]
// ----------------------------------------------------------------------------
// i2c_target_memory_backend
// Back end of a 10-bit-address I2C target serving a byte memory through a
// phase machine and an auto-incrementing memory pointer.
//
//   Channel | Direction | Payload | Handshake
//   req     | in        | req_t   | req_valid / req_ready
//   rsp     | out       | rsp_t   | rsp_valid / rsp_ready
//
// A request passes from ST_IDLE through ST_DONE to the response register; it
// also passes ST_READ when it reads the memory, or ST_REDUCE when it sets the
// pointer (three-step modulo reduction). One request is in progress at a time.
// After reset a clearing pass writes zero to all MEM_DEPTH entries, one per
// cycle, and no request is taken during the pass.
// A stalled response holds in its register; the next request is still taken
// and waits for the register to free before its result is loaded.
// ----------------------------------------------------------------------------
module i2c_target_memory_backend
	import i2ctmb_pkg::*;
#(
	parameter int unsigned MEM_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned PW = $clog2(MEM_DEPTH);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_REDUCE = 5'b01000,
		ST_DONE   = 5'b10000
	} ctl_state_t;

	ctl_state_t    state_q;
	logic [2:0]    phase_q;
	logic [1:0]    count_q;
	logic [7:0]    hi_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] clr_q;
	rsp_t          res_q;
	rsp_t          out_q;
	logic          out_valid_q;

	logic          accept;
	logic          load_out;
	logic          do_read, do_store, do_reduce, set_hi;
	logic [2:0]    nxt_phase;
	logic [1:0]    nxt_count;
	logic [PW-1:0] ptr_inc;
	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic          red_done;
	logic [PW-1:0] red_result;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp_ready);
	assign ptr_inc   = (ptr_q == PW'(MEM_DEPTH - 1)) ? '0 : (ptr_q + 1'b1);

	// Event decode against the current phase and byte count.
	always_comb begin
		nxt_phase = phase_q;
		nxt_count = count_q;
		do_read   = 1'b0;
		do_store  = 1'b0;
		do_reduce = 1'b0;
		set_hi    = 1'b0;
		case (req.operation)
			OP_START: begin
				nxt_count = 2'd0;
				nxt_phase = PH_H_RD;
			end
			OP_ACK: begin
				case (phase_q)
					PH_H_WR: begin
						nxt_count = 2'd0;
						nxt_phase = PH_L_WR;
					end
					PH_H_RD: begin
						nxt_count = 2'd0;
						do_read   = 1'b1;
					end
					PH_L_WR: begin
						if (req.read_direction) begin
							do_read = 1'b1;
						end else begin
							nxt_phase = PH_DATA;
						end
					end
					PH_L_RD: begin
						do_read = 1'b1;
					end
					PH_DATA: begin
						case (count_q)
							2'd0: begin
								set_hi    = 1'b1;
								nxt_count = 2'd1;
							end
							2'd1: begin
								do_reduce = 1'b1;
								nxt_count = 2'd2;
							end
							default: begin
								// A count of two, or the unreachable three.
								do_store  = 1'b1;
								nxt_count = 2'd0;
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			default: begin
				// Nack or stop.
				nxt_count = 2'd0;
				nxt_phase = PH_H_WR;
			end
		endcase
	end

	// Memory write port: clearing pass after reset, then data stores.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 8'd0;
		end else begin
			mem_we    = accept && do_store;
			mem_waddr = ptr_q;
			mem_wdata = req.rx_byte;
		end
	end

	i2ctmb_mem #(
		.MEM_DEPTH(MEM_DEPTH),
		.PW       (PW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept && do_read),
		.raddr(ptr_q),
		.rdata(mem_rdata)
	);

	i2ctmb_ptr_reduce #(
		.MEM_DEPTH(MEM_DEPTH),
		.PW       (PW)
	) u_reduce (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && do_reduce),
		.value ({hi_q, req.rx_byte}),
		.done  (red_done),
		.result(red_result)
	);

	// Control sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			phase_q     <= PH_H_WR;
			count_q     <= 2'd0;
			hi_q        <= 8'd0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The response is valid from its load until it is taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_valid && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PW'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						phase_q <= nxt_phase;
						count_q <= nxt_count;
						if (set_hi) begin
							hi_q <= req.rx_byte;
						end
						if (do_read) begin
							ptr_q   <= ptr_inc;
							state_q <= ST_READ;
						end else if (do_reduce) begin
							state_q <= ST_REDUCE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_REDUCE: begin
					if (red_done) begin
						ptr_q   <= red_result;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result and response payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= '0;
		end else if (state_q == ST_READ) begin
			res_q.tx_valid <= 1'b1;
			res_q.tx_byte  <= mem_rdata;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[design/i2ctmb_checker.sv]
// ----------------------------------------------------------------------------
// i2ctmb_checker
// Port-level checks on the I2C target memory back end, bound to its top level.
// ----------------------------------------------------------------------------
module i2ctmb_checker
	import i2ctmb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// A byte is only non-zero when it is flagged for transmission.
	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.tx_valid) |-> (rsp.tx_byte == 8'd0))
		else $error("response byte non-zero without tx_valid");

	// A stalled response keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

	// Requests are handled one at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in progress");

	// A request accepted after an idle output yields no response next cycle.
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
		else $error("response appeared too early");

endmodule

bind i2c_target_memory_backend i2ctmb_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
